@@ rtl/core/sse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types and constants for the spline segment evaluator.
// ----------------------------------------------------------------------------
package sse_pkg;

  // Field widths
  localparam int T_W     = 19;   // t_param, signed Q2.16
  localparam int CNT_W   = 5;    // segment_count
  localparam int COEF_W  = 32;   // coefficient / result word
  localparam int SEG_W   = 4;    // seg_index / seg_used
  localparam int SLOT_W  = 4;    // coeff_index
  localparam int PROD_W  = T_W + CNT_W + 1;  // t * count and local parameter

  // Store layout: one row per segment, four slots per axis
  localparam int AXES    = 3;
  localparam int PER_AXIS = 4;
  localparam int SLOTS   = AXES * PER_AXIS;
  localparam int ROW_W   = SLOTS * COEF_W;

  // Operation codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  // Register byte addresses
  localparam logic [0:0] ADDR_SEG_COUNT = 1'b0;

  // Stream payload widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 296;

  // Per-axis result of the polynomial pipeline
  typedef struct packed {
    logic signed [COEF_W-1:0] pos;
    logic signed [COEF_W-1:0] vel;
    logic signed [COEF_W-1:0] acc;
  } axis_res_t;

endpackage

@@ rtl/core/sse_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_ram
// Simple dual-port RAM with per-lane write enables and a registered read.
// ----------------------------------------------------------------------------
module sse_ram #(
  parameter int WIDTH  = 384,
  parameter int DEPTH  = 16,
  parameter int LANE_W = 32,
  localparam int LANES = WIDTH / LANE_W,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [LANES-1:0] lane_en,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Lane writes
  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < LANES; i++) begin
        if (lane_en[i]) begin
          mem[waddr][i*LANE_W +: LANE_W] <= wdata[i*LANE_W +: LANE_W];
        end
      end
    end
  end

  // Registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/sse_poly.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_poly
// Six-stage Horner pipeline for one axis: position, first and second
// derivative, with round-half-up products and 32-bit saturation.
// ----------------------------------------------------------------------------
module sse_poly #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [4*sse_pkg::COEF_W-1:0]         coeffs,
  input  logic signed [sse_pkg::PROD_W-1:0]    lpar,
  output sse_pkg::axis_res_t                   res
);

  localparam int CW = sse_pkg::COEF_W;
  localparam int LW = sse_pkg::PROD_W;
  localparam int PW = CW + 3 + LW;
  localparam logic signed [PW:0]   HALF = (PW+1)'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [PW+1:0] SMAX = (PW+2)'(64'sh7FFFFFFF);
  localparam logic signed [PW+1:0] SMIN = -SMAX - (PW+2)'(1);

  // Round product to FRAC_BITS, add term, saturate to 32 bits
  function automatic logic signed [CW-1:0] ras(input logic signed [PW-1:0] p,
                                               input logic signed [CW+1:0] c);
    logic signed [PW:0]   r;
    logic signed [PW+1:0] s;
    r = ((PW+1)'(p) + HALF) >>> FRAC_BITS;
    s = (PW+2)'(r) + (PW+2)'(c);
    if (s > SMAX) begin
      ras = {1'b0, {(CW-1){1'b1}}};
    end else if (s < SMIN) begin
      ras = {1'b1, {(CW-1){1'b0}}};
    end else begin
      ras = s[CW-1:0];
    end
  endfunction

  logic signed [CW-1:0] c0, c1, c2, c3;
  logic signed [CW+1:0] c3x3;
  logic signed [CW+2:0] c3x6;

  assign c0   = coeffs[0*CW +: CW];
  assign c1   = coeffs[1*CW +: CW];
  assign c2   = coeffs[2*CW +: CW];
  assign c3   = coeffs[3*CW +: CW];
  assign c3x3 = ((CW+2)'(c3) <<< 1) + (CW+2)'(c3);
  assign c3x6 = (CW+3)'(c3x3) <<< 1;

  // Stage 1: leading products
  logic signed [PW-1:0] s1_pm, s1_vm, s1_am;
  logic signed [CW-1:0] s1_c0, s1_c1, s1_c2;
  logic signed [LW-1:0] s1_l;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_pm <= PW'(c3) * PW'(lpar);
      s1_vm <= PW'(c3x3) * PW'(lpar);
      s1_am <= PW'(c3x6) * PW'(lpar);
      s1_c0 <= c0;
      s1_c1 <= c1;
      s1_c2 <= c2;
      s1_l  <= lpar;
    end
  end

  // Stage 2: first accumulate; acceleration is done here
  logic signed [CW-1:0] s2_p, s2_v, s2_a, s2_c0, s2_c1;
  logic signed [LW-1:0] s2_l;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_p  <= ras(s1_pm, (CW+2)'(s1_c2));
      s2_v  <= ras(s1_vm, (CW+2)'(s1_c2) <<< 1);
      s2_a  <= ras(s1_am, (CW+2)'(s1_c2) <<< 1);
      s2_c0 <= s1_c0;
      s2_c1 <= s1_c1;
      s2_l  <= s1_l;
    end
  end

  // Stage 3: second products
  logic signed [PW-1:0] s3_pm, s3_vm;
  logic signed [CW-1:0] s3_a, s3_c0, s3_c1;
  logic signed [LW-1:0] s3_l;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_pm <= PW'(s2_p) * PW'(s2_l);
      s3_vm <= PW'(s2_v) * PW'(s2_l);
      s3_a  <= s2_a;
      s3_c0 <= s2_c0;
      s3_c1 <= s2_c1;
      s3_l  <= s2_l;
    end
  end

  // Stage 4: second accumulate; velocity is done here
  logic signed [CW-1:0] s4_p, s4_v, s4_a, s4_c0;
  logic signed [LW-1:0] s4_l;
  always_ff @(posedge clk) begin
    if (en) begin
      s4_p  <= ras(s3_pm, (CW+2)'(s3_c1));
      s4_v  <= ras(s3_vm, (CW+2)'(s3_c1));
      s4_a  <= s3_a;
      s4_c0 <= s3_c0;
      s4_l  <= s3_l;
    end
  end

  // Stage 5: last position product
  logic signed [PW-1:0] s5_pm;
  logic signed [CW-1:0] s5_v, s5_a, s5_c0;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_pm <= PW'(s4_p) * PW'(s4_l);
      s5_v  <= s4_v;
      s5_a  <= s4_a;
      s5_c0 <= s4_c0;
    end
  end

  // Stage 6: final position
  always_ff @(posedge clk) begin
    if (en) begin
      res.pos <= ras(s5_pm, (CW+2)'(s5_c0));
      res.vel <= s5_v;
      res.acc <= s5_a;
    end
  end

endmodule

@@ rtl/core/spline_segment_evaluator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spline_segment_evaluator
// Piecewise cubic spline evaluator over a segment coefficient RAM.
// ----------------------------------------------------------------------------
// One item is taken per clock while s_tready is high. A write item (tuser = 0)
// stores one coefficient into its lane of the segment row and returns nothing;
// an evaluate item (tuser = 1) returns one result through the RAM read, the axis
// pipelines and the output register. Throughput is set by the coefficient RAM,
// which delivers a whole 12-coefficient row per cycle when not stalled, and the
// three axis pipelines behind it. A write is visible to an evaluation taken in
// the next cycle. A two-entry output stage (register plus skid) lets the pipeline
// run on while a result waits; s_tready drops only once both entries are full.
// Coefficients must be written before the segments that use them are evaluated.
module spline_segment_evaluator #(
  parameter int MAX_SEGMENTS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // [3:0] seg_index, [7:4] coeff_index, [39:8] coeff_value, [58:40] t_param
  input  logic [sse_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] func
  input  logic [0:0]   s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [127:96] vel_x,
  // [159:128] vel_y, [191:160] vel_z, [223:192] acc_x, [255:224] acc_y,
  // [287:256] acc_z, [291:288] seg_used
  output logic [sse_pkg::OUT_DATA_W-1:0] m_tdata,
  // [0] is_empty
  output logic [0:0]   m_tuser,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [0:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW    = sse_pkg::COEF_W;
  localparam int LW    = sse_pkg::PROD_W;
  localparam int CNT_W = sse_pkg::CNT_W;
  localparam int DEPTH = 6;

  // Configuration register
  logic [CNT_W-1:0] segment_count;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == sse_pkg::ADDR_SEG_COUNT) begin
      segment_count <= pwdata[CNT_W-1:0];
    end
  end
  assign prdata = (paddr == sse_pkg::ADDR_SEG_COUNT) ?
                  {{(32-CNT_W){1'b0}}, segment_count} : '0;

  // Input fields
  logic [sse_pkg::SEG_W-1:0]     in_seg;
  logic [sse_pkg::SLOT_W-1:0]    in_slot;
  logic [CW-1:0]                 in_coef;
  logic signed [sse_pkg::T_W-1:0] in_t;

  assign in_seg  = s_tdata[3:0];
  assign in_slot = s_tdata[7:4];
  assign in_coef = s_tdata[39:8];
  assign in_t    = s_tdata[58:40];

  logic advance, accept, do_write, do_eval;
  logic skid_valid;

  assign advance  = !skid_valid;
  assign s_tready = advance;
  assign accept   = s_tvalid && s_tready;
  assign do_write = accept && s_tuser[0] == sse_pkg::FUNC_WRITE;
  assign do_eval  = accept && s_tuser[0] == sse_pkg::FUNC_EVAL;

  // Segment selection and local parameter
  logic [CNT_W-1:0]     cnt_eff;
  logic signed [LW-1:0] prod, seg_raw, seg_sel, cnt_m1, lpar;

  always_comb begin
    cnt_eff = (int'(segment_count) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : segment_count;
    prod    = LW'(in_t) * $signed(LW'(cnt_eff));
    seg_raw = prod >>> FRAC_BITS;
    cnt_m1  = $signed(LW'(cnt_eff)) - LW'(1);
    if (seg_raw < 0 || cnt_eff == '0) begin
      seg_sel = '0;
    end else if (seg_raw > cnt_m1) begin
      seg_sel = cnt_m1;
    end else begin
      seg_sel = seg_raw;
    end
    lpar = prod - (seg_sel <<< FRAC_BITS);
  end

  // Write lane decode; slots past the last are dropped
  logic [sse_pkg::SLOTS-1:0] lane_en;
  logic                      wr_ok;

  assign lane_en = (int'(in_slot) < sse_pkg::SLOTS) ?
                   sse_pkg::SLOTS'(1) << in_slot : '0;
  assign wr_ok   = do_write && int'(in_seg) < MAX_SEGMENTS;

  // Coefficient RAM: read at transfer, data valid in the next cycle
  logic [sse_pkg::ROW_W-1:0] row;

  sse_ram #(
    .WIDTH  (sse_pkg::ROW_W),
    .DEPTH  (MAX_SEGMENTS),
    .LANE_W (CW)
  ) u_ram (
    .clk     (clk),
    .we      (wr_ok),
    .lane_en (lane_en),
    .waddr   (AW'(in_seg)),
    .wdata   ({sse_pkg::SLOTS{in_coef}}),
    .re      (advance),
    .raddr   (AW'(seg_sel)),
    .rdata   (row)
  );

  // Front stage register beside the RAM read
  logic                      f_valid, f_empty;
  logic [sse_pkg::SEG_W-1:0] f_seg;
  logic signed [LW-1:0]      f_lpar;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (advance) begin
      f_valid <= do_eval;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      f_empty <= cnt_eff == '0;
      f_seg   <= sse_pkg::SEG_W'(seg_sel);
      f_lpar  <= lpar;
    end
  end

  // Axis pipelines
  sse_pkg::axis_res_t ax_res [sse_pkg::AXES];

  for (genvar a = 0; a < sse_pkg::AXES; a++) begin : g_axis
    sse_poly #(
      .FRAC_BITS (FRAC_BITS)
    ) u_poly (
      .clk    (clk),
      .en     (advance),
      .coeffs (row[a*4*CW +: 4*CW]),
      .lpar   (f_lpar),
      .res    (ax_res[a])
    );
  end

  // Side-band pipe matching the axis pipelines
  logic [DEPTH-1:0]          p_valid;
  logic [DEPTH-1:0]          p_empty;
  logic [sse_pkg::SEG_W-1:0] p_seg [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= '0;
    end else if (advance) begin
      p_valid <= {p_valid[DEPTH-2:0], f_valid};
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      p_empty <= {p_empty[DEPTH-2:0], f_empty};
      p_seg[0] <= f_seg;
      for (int i = 1; i < DEPTH; i++) begin
        p_seg[i] <= p_seg[i-1];
      end
    end
  end

  // Result assembly; empty spline forces zeros
  logic                               r_valid;
  logic [sse_pkg::OUT_DATA_W-1:0]     r_data;
  logic                               r_empty;

  assign r_valid = advance && p_valid[DEPTH-1];
  assign r_empty = p_empty[DEPTH-1];
  always_comb begin
    if (r_empty) begin
      r_data = '0;
    end else begin
      r_data = {4'b0, p_seg[DEPTH-1],
                ax_res[2].acc, ax_res[1].acc, ax_res[0].acc,
                ax_res[2].vel, ax_res[1].vel, ax_res[0].vel,
                ax_res[2].pos, ax_res[1].pos, ax_res[0].pos};
    end
  end

  // Output register with skid entry
  logic [sse_pkg::OUT_DATA_W-1:0] skid_data;
  logic                           skid_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= r_valid;
      end
    end else if (r_valid) begin
      skid_valid <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
        m_tuser <= skid_empty;
      end else begin
        m_tdata <= r_data;
        m_tuser <= r_empty;
      end
    end else if (r_valid) begin
      skid_data  <= r_data;
      skid_empty <= r_empty;
    end
  end

`ifndef SYNTH
  // Skid holds data only behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry valid with empty output register");

  // Skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid filled without output stall");

  // Empty-spline results carry all-zero data
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("empty result with nonzero data");
`endif

endmodule
